// ===== rtl/bglr_pkg.sv =====
package bglr_pkg;

	localparam int MaxElements = 64;
	localparam int AddrW = $clog2(MaxElements);
	localparam int CountW = $clog2(MaxElements + 1);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_NO_CHANGE = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	localparam logic [0:0] REG_ALPHA = 1'b0;
	localparam logic [0:0] REG_ITER = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] element_value;
		logic [30:0] element_weight;
		logic [30:0] left_end;
		logic [30:0] right_end;
		logic [30:0] grp_coef;
	} in_item_t;

	typedef struct packed {
		logic [30:0] root;
		logic [1:0]  status;
	} out_item_t;

	// Opcodes for the shared multiplier.
	typedef enum logic [2:0] {
		MUL_OMA,
		MUL_C,
		MUL_AW,
		MUL_P,
		MUL_SQ,
		MUL_CL,
		MUL_GRP,
		MUL_GHI
	} mul_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OMA,
		S_C,
		S_START,
		S_READ,
		S_AW,
		S_PT,
		S_SQ,
		S_ACC,
		S_GCL,
		S_GRP,
		S_GHI,
		S_CMP,
		S_DECIDE,
		S_OUT
	} state_t;

endpackage

// ===== rtl/bglr_mul.sv =====
// Shared 33x33 multiplier with registered product.
module bglr_mul (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [65:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

// ===== rtl/bisection_group_lasso_root.sv =====
// Bisection root finder for the group-lasso step polynomial, Q16.16 fixed point.
// Input channel (in_valid/in_ready/in_data): a load beat stores one (value,
// weight) pair, up to 64 elements; further loads are dropped. A solve beat
// starts the bisection over the stored elements and later yields one result
// beat (root, status) on out_valid/out_ready. A solve runs at most
// iteration_limit + 1 bisection passes.
// One shared 33x33 multiplier does every product in turn: each element costs
// three multiplies per point, the group term is built in the GCL, GRP and GHI
// states, and the element memory is read once per element and point.
// in_ready is low during a solve and while a result waits to be taken.
// If the receiver stalls, the result is held stable until taken.
// Reset clears the element count, the result flag and the registers alpha
// (32768) and iteration_limit (40); the element memory is left unset.
// APB: alpha at address 0, iteration_limit at address 4; pready is high.
module bisection_group_lasso_root (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bglr_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bglr_pkg::out_item_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import bglr_pkg::*;

	state_t state_q, state_d;
	logic [15:0] alpha_q;
	logic [5:0] iter_q;
	logic [CountW-1:0] count_q;
	logic [AddrW-1:0] idx_q;
	logic [1:0] k_q;
	logic [31:0] left_q, right_q, mid_q, mag_q, p_q;
	logic [31:0] c_q;
	logic [30:0] g_q;
	logic [63:0] grp_q;
	logic [63:0] acc_q [3];
	logic [1:0] sg_q [3];
	logic [5:0] steps_q;
	logic [31:0] vmem [MaxElements];
	logic [31:0] wmem [MaxElements];
	logic [31:0] rv_q, rw_q;
	logic [32:0] ma, mb;
	logic [65:0] prod;
	mul_op_t op;
	out_item_t res_q;
	logic outv_q;
	logic wr;
	logic done;
	logic [1:0] fin_status;
	logic p_big;
	logic [31:0] p_now;
	logic [64:0] gsum;
	logic [63:0] gval;

	bglr_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod_q(prod));

	// APB register file.
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd32768;
			iter_q <= 6'd40;
		end else if (wr) begin
			case (paddr[2])
				REG_ALPHA: alpha_q <= pwdata[15:0];
				REG_ITER: iter_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			REG_ALPHA: prdata = {16'd0, alpha_q};
			REG_ITER: prdata = {26'd0, iter_q};
			default: prdata = '0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE) && !outv_q;
	assign out_valid = outv_q;
	assign out_data = res_q;

	// Current evaluation point.
	logic [31:0] pt;
	always_comb begin
		case (k_q)
			2'd0: pt = left_q;
			2'd1: pt = mid_q;
			default: pt = right_q;
		endcase
	end

	// Penalty product of the element at the current point, saturated to 32 bits.
	assign p_big = |prod[65:48];
	assign p_now = p_big ? '1 : prod[47:16];

	// Group term from its low and high partial products, saturating at 2^64-1.
	assign gsum = {1'b0, prod[31:0], 32'd0} + {1'b0, grp_q};
	assign gval = (prod[65:32] != '0 || gsum[64]) ? '1 : gsum[63:0];

	// Multiplier operand select.
	always_comb begin
		ma = '0;
		mb = '0;
		case (op)
			MUL_OMA: begin
				ma = 33'(17'h10000 - {1'b0, alpha_q});
				mb = 33'(17'h10000 - {1'b0, alpha_q});
			end
			MUL_C: begin
				ma = 33'(prod[47:16]);
				mb = 33'(g_q);
			end
			MUL_AW: begin
				ma = 33'(alpha_q);
				mb = 33'(rw_q);
			end
			MUL_P: begin
				ma = 33'(prod[47:16]);
				mb = 33'(pt);
			end
			MUL_SQ: begin
				ma = 33'(mag_q - p_now);
				mb = 33'(mag_q - p_now);
			end
			MUL_CL: begin
				ma = 33'(c_q);
				mb = 33'(pt);
			end
			MUL_GRP: begin
				ma = 33'(prod[47:16]);
				mb = 33'(pt);
			end
			MUL_GHI: begin
				ma = 33'(grp_q[63:32]);
				mb = 33'(pt);
			end
			default: ;
		endcase
	end

	// Next state.
	logic left_chg, right_chg;
	assign left_chg = (sg_q[0] == 2'b01 && sg_q[1] == 2'b11) ||
		(sg_q[0] == 2'b11 && sg_q[1] == 2'b01);
	assign right_chg = (sg_q[1] == 2'b01 && sg_q[2] == 2'b11) ||
		(sg_q[1] == 2'b11 && sg_q[2] == 2'b01);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid && in_ready && in_data.command == CMD_SOLVE)
				state_d = S_OMA;
			S_OMA: state_d = S_C;
			S_C: state_d = S_START;
			S_START: state_d = (count_q == '0) ? S_GCL : S_READ;
			S_READ: state_d = S_AW;
			S_AW: state_d = S_PT;
			S_PT: state_d = S_SQ;
			S_SQ: state_d = S_ACC;
			S_ACC: state_d = ({1'b0, idx_q} == count_q - 1'b1) ? S_GCL : S_READ;
			S_GCL: state_d = S_GRP;
			S_GRP: state_d = S_GHI;
			S_GHI: state_d = S_CMP;
			S_CMP: state_d = (k_q == 2'd2) ? S_DECIDE :
				(count_q == '0 ? S_GCL : S_READ);
			S_DECIDE: state_d = S_START;
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_DECIDE && done) state_d = S_OUT;
	end

	// Multiplier opcode for each state.
	always_comb begin
		case (state_q)
			S_OMA: op = MUL_OMA;
			S_C: op = MUL_C;
			S_AW: op = MUL_AW;
			S_PT: op = MUL_P;
			S_SQ: op = MUL_SQ;
			S_GCL: op = MUL_CL;
			S_GRP: op = MUL_GRP;
			S_GHI: op = MUL_GHI;
			default: op = MUL_AW;
		endcase
	end

	// Decision logic.
	logic [31:0] dl, dr;
	assign dl = (left_q > mid_q) ? left_q - mid_q : mid_q - left_q;
	assign dr = (mid_q > right_q) ? mid_q - right_q : right_q - mid_q;
	always_comb begin
		done = 1'b1;
		fin_status = ST_NO_CHANGE;
		if (left_chg) begin
			if (dl <= 32'd1) fin_status = ST_CONVERGED;
			else if (steps_q >= iter_q) fin_status = ST_LIMIT;
			else done = 1'b0;
		end else if (right_chg) begin
			if (dr <= 32'd1) fin_status = ST_CONVERGED;
			else if (steps_q >= iter_q) fin_status = ST_LIMIT;
			else done = 1'b0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			outv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (outv_q && out_ready) outv_q <= 1'b0;
			if (state_q == S_OUT) begin
				outv_q <= 1'b1;
				count_q <= '0;
			end
			if (state_q == S_IDLE && in_valid && in_ready &&
				in_data.command == CMD_LOAD && count_q < CountW'(MaxElements))
				count_q <= count_q + 1'b1;
		end
	end

	// Element memory.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready &&
			in_data.command == CMD_LOAD && count_q < CountW'(MaxElements)) begin
			vmem[count_q[AddrW-1:0]] <= in_data.element_value;
			wmem[count_q[AddrW-1:0]] <= {1'b0, in_data.element_weight};
		end
		rv_q <= vmem[idx_q];
		rw_q <= wmem[idx_q];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				left_q <= {1'b0, in_data.left_end};
				right_q <= {1'b0, in_data.right_end};
				g_q <= in_data.grp_coef;
				steps_q <= '0;
			end
			S_C: ;
			S_START: begin
				// The group coefficient is ready only on the first pass.
				if (steps_q == '0) c_q <= prod[47:16];
				mid_q <= 32'((33'(left_q) + 33'(right_q)) >> 1);
				k_q <= 2'd0;
				idx_q <= '0;
				acc_q[0] <= '0;
				acc_q[1] <= '0;
				acc_q[2] <= '0;
			end
			S_AW: mag_q <= rv_q[31] ? (~rv_q + 32'd1) : rv_q;
			S_PT: ;
			S_SQ: p_q <= p_now;
			S_ACC: begin
				if (mag_q > p_q) begin
					acc_q[k_q] <= (acc_q[k_q] + prod[63:0] < acc_q[k_q]) ?
						'1 : acc_q[k_q] + prod[63:0];
				end
				idx_q <= idx_q + 1'b1;
			end
			S_GCL: ;
			S_GRP: grp_q <= 64'(prod[65:16]);
			S_GHI: grp_q <= prod[63:0];
			S_CMP: begin
				if (acc_q[k_q] > gval) begin
					sg_q[k_q] <= 2'b01;
				end else if (acc_q[k_q] < gval) begin
					sg_q[k_q] <= 2'b11;
				end else begin
					sg_q[k_q] <= 2'b00;
				end
				k_q <= k_q + 2'd1;
				idx_q <= '0;
			end
			S_DECIDE: begin
				if (left_chg) right_q <= mid_q;
				else left_q <= mid_q;
				steps_q <= steps_q + 6'd1;
				res_q.root <= mid_q[30:0];
				res_q.status <= fin_status;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/bglr_checker.sv =====
module bglr_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input bglr_pkg::out_item_t out_data
);
	import bglr_pkg::*;

	// A result that is stalled holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// No input is taken while a result waits.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	// Status is always a defined code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_LIMIT)
		else $error("bad status");
endmodule

bind bisection_group_lasso_root bglr_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/sv/bglr_checker.sv =====
`timescale 1ns / 1ps

module bglr_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  bglr_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  bglr_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  mismatches,
	output int                  roots_pending,
	output int                  roots_checked
);
	import bglr_pkg::*;

	localparam longint unsigned SatMax = 64'hFFFF_FFFF_FFFF_FFFF;

	// Shadow copy of the element memory and the registers.
	logic [31:0] val_mem [MaxElements];
	logic [30:0] wgt_mem [MaxElements];
	int          elem_cnt;
	logic [15:0] alpha_q;
	logic [5:0]  iter_lim;
	out_item_t   root_q[$];

	function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s < a) ? SatMax : s;
	endfunction

	// Bisection over the loaded elements; returns the predicted root beat.
	function automatic out_item_t bisect_root(logic [30:0] lb, logic [30:0] rb,
		logic [30:0] g);
		longint unsigned oma, gc, aw, p, mag, d, t, grp;
		longint unsigned sums [3];
		logic [127:0] wide;
		logic [31:0] lft, rgt, mid, raw;
		logic [31:0] pts [3];
		int sg [3];
		int steps;
		logic [1:0] st;
		out_item_t r;
		lft = {1'b0, lb};
		rgt = {1'b0, rb};
		oma = 64'd65536 - alpha_q;
		gc = (((oma * oma) >> 16) * g) >> 16;
		steps = 0;
		while (1) begin
			mid = (lft + rgt) >> 1;
			pts[0] = lft;
			pts[1] = mid;
			pts[2] = rgt;
			for (int k = 0; k < 3; k++) sums[k] = 0;
			for (int j = 0; j < elem_cnt; j++) begin
				raw = val_mem[j];
				mag = raw[31] ? {32'd0, -raw} : {32'd0, raw};
				aw = (longint'(alpha_q) * wgt_mem[j]) >> 16;
				for (int k = 0; k < 3; k++) begin
					p = (aw * pts[k]) >> 16;
					if (mag > p) begin
						d = mag - p;
						sums[k] = add_sat(sums[k], d * d);
					end
				end
			end
			// Sign of the sum minus the saturating group term.
			for (int k = 0; k < 3; k++) begin
				t = (gc * pts[k]) >> 16;
				wide = {64'd0, t} * {96'd0, pts[k]};
				grp = (wide[127:64] != 0) ? SatMax : wide[63:0];
				sg[k] = (sums[k] > grp) ? 1 : (sums[k] < grp) ? -1 : 0;
			end
			if (sg[0] * sg[1] < 0) begin
				if (((lft > mid) ? lft - mid : mid - lft) <= 1) begin
					st = ST_CONVERGED;
					break;
				end
				if (steps >= iter_lim) begin
					st = ST_LIMIT;
					break;
				end
				rgt = mid;
			end else if (sg[1] * sg[2] < 0) begin
				if (((mid > rgt) ? mid - rgt : rgt - mid) <= 1) begin
					st = ST_CONVERGED;
					break;
				end
				if (steps >= iter_lim) begin
					st = ST_LIMIT;
					break;
				end
				lft = mid;
			end else begin
				st = ST_NO_CHANGE;
				break;
			end
			steps++;
		end
		r.root = mid[30:0];
		r.status = st;
		return r;
	endfunction

	assign roots_pending = root_q.size();

	// Track register writes, input beats and result beats.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			elem_cnt <= 0;
			alpha_q <= 16'd32768;
			iter_lim <= 6'd40;
			mismatches <= 0;
			roots_checked <= 0;
			root_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ALPHA) alpha_q <= pwdata[15:0];
				else iter_lim <= pwdata[5:0];
			end
			if (in_valid && in_ready) begin
				if (in_data.command == CMD_LOAD) begin
					if (elem_cnt < MaxElements) begin
						val_mem[elem_cnt] = in_data.element_value;
						wgt_mem[elem_cnt] = in_data.element_weight;
						elem_cnt <= elem_cnt + 1;
					end
				end else begin
					root_q.push_back(bisect_root(in_data.left_end,
						in_data.right_end, in_data.grp_coef));
					elem_cnt <= 0;
				end
			end
			if (out_valid && out_ready) begin
				if (root_q.size() == 0) begin
					$display("%0t: unexpected result beat root=%h status=%0d", $time,
						out_data.root, out_data.status);
					mismatches <= mismatches + 1;
				end else begin
					want = root_q.pop_front();
					roots_checked <= roots_checked + 1;
					if (want.root !== out_data.root || want.status !== out_data.status) begin
						$display("%0t: mismatch expected root=%h status=%0d, %s%h status=%0d",
							$time, want.root, want.status, "got root=",
							out_data.root, out_data.status);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import bglr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          mismatches, roots_pending, roots_checked;
	int          gap_pct, stall_pct;
	int          n_loads, n_solves;
	logic        hold_req, hold_done;
	int          hold_cnt;

	bisection_group_lasso_root uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bglr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .roots_pending(roots_pending),
		.roots_checked(roots_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= 400;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_beat(in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic load_elem(logic [31:0] v, logic [30:0] w);
		in_item_t it;
		logic [191:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.command = CMD_LOAD;
		it.element_value = v;
		it.element_weight = w;
		n_loads++;
		send_beat(it);
	endtask

	task automatic solve_root(logic [30:0] l, logic [30:0] r, logic [30:0] g);
		in_item_t it;
		logic [191:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.command = CMD_SOLVE;
		it.left_end = l;
		it.right_end = r;
		it.grp_coef = g;
		n_solves++;
		send_beat(it);
	endtask

	// Stop sending and wait for every pending result, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (roots_pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_write(logic [0:0] idx, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(0, 20 << 16);
			2: v = $urandom_range(0, 65535);
			default: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		endcase
		if ($urandom_range(1)) v = -v;
		return v;
	endfunction

	function automatic logic [30:0] rand_small(int top_val);
		logic [31:0] v;
		v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, top_val);
		return v[30:0];
	endfunction

	initial begin
		int k;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		hold_req <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		n_loads = 0;
		n_solves = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty solve, extreme values, reversed and degenerate borders.
		solve_root(31'd0, 31'(100 << 16), 31'(1 << 16));
		load_elem(32'h8000_0000, 31'd0);
		load_elem(32'h7FFF_FFFF, 31'h7FFF_FFFF);
		load_elem(32'd0, 31'(1 << 16));
		load_elem(32'hFFF0_0000, 31'(1 << 16));
		solve_root(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		load_elem(32'(3 << 16), 31'(1 << 16));
		load_elem(-32'(2 << 16), 31'(2 << 16));
		solve_root(31'(40 << 16), 31'd0, 31'(1 << 16));
		load_elem(32'(3 << 16), 31'(1 << 16));
		solve_root(31'(5 << 16), 31'(5 << 16), 31'd0);
		drain();
		// A limit of zero stops at the first halving.
		apb_write(REG_ITER, 32'd0);
		apb_write(REG_ALPHA, 32'd0);
		load_elem(32'(4 << 16), 31'(1 << 16));
		load_elem(-32'(1 << 16), 31'(3 << 16));
		solve_root(31'd0, 31'(64 << 16), 31'(2 << 16));
		drain();
		apb_write(REG_ITER, 32'd63);
		apb_write(REG_ALPHA, 32'hFFFF);
		load_elem(32'(7 << 16), 31'(1 << 16));
		solve_root(31'd0, 31'(64 << 16), 31'h7FFF_FFFF);
		drain();
		apb_write(REG_ITER, 32'd1);
		load_elem(32'(7 << 16), 31'(2 << 16));
		solve_root(31'(30 << 16), 31'd0, 31'(1 << 16));
		drain();

		// Random phases with different idling and register settings.
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = (ph == 1) ? 53 : (ph == 3) ? 18 : 0;
			stall_pct = (ph == 2) ? 53 : (ph == 3) ? 18 : 0;
			apb_write(REG_ALPHA, (ph == 0) ? 32'd32768 : 32'($urandom_range(0, 65535)));
			apb_write(REG_ITER, (ph == 3) ? 32'd48 : 32'($urandom_range(1, 48)));
			while (n_loads + n_solves < 30 + 380 * (ph + 1)) begin
				if (ph == 2 && n_solves % 20 == 0) hold_req <= 1'b1;
				k = ($urandom_range(59) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
				for (int j = 0; j < k; j++)
					load_elem(rand_value(), rand_small(4 << 16));
				if ($urandom_range(9) == 0) begin
					// Sender pauses until the block has returned every result.
					drain();
				end
				solve_root(rand_small(4 << 16), rand_small(64 << 16), rand_small(16 << 16));
			end
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Covered %0d loads and %0d solves over four idling phases; %0d roots checked.",
			n_loads, n_solves, roots_checked);
		if (mismatches == 0 && roots_pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== bisection_group_lasso_root.f =====
rtl/bglr_pkg.sv
rtl/bglr_mul.sv
rtl/bisection_group_lasso_root.sv
rtl/bglr_checker.sv
tb/sv/bglr_checker.sv
tb/sv/tb_top.sv
